FILE: rtl/core/dtsp_pkg.sv
// Shared types, widths and codes for the date-time string parser.
`default_nettype none
package dtsp_pkg;

	localparam int STRING_SIZE_DEF = 20;
	localparam int NUM_FIELDS      = 6;
	localparam int FIELD_W         = 14;
	localparam int SEEN_W          = 3;
	localparam int STATUS_W        = 3;
	localparam int ACC_W           = 17;

	localparam logic [FIELD_W-1:0] SAT_VALUE  = 14'd10000;
	localparam logic [FIELD_W-1:0] YEAR_MAX   = 14'd9999;
	localparam logic [FIELD_W-1:0] MONTH_MAX  = 14'd12;
	localparam logic [FIELD_W-1:0] DAY_MAX    = 14'd31;
	localparam logic [FIELD_W-1:0] HOUR_MAX   = 14'd23;
	localparam logic [FIELD_W-1:0] MINSEC_MAX = 14'd59;

	localparam logic [7:0] CHAR_NUL  = 8'h00;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	localparam logic [SEEN_W-1:0] SEEN_MAX = 3'd7;

	localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_FORMAT = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_YEAR   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_MONTH  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_BAD_DAY    = 3'd4;
	localparam logic [STATUS_W-1:0] ST_BAD_HOUR   = 3'd5;
	localparam logic [STATUS_W-1:0] ST_BAD_MINUTE = 3'd6;
	localparam logic [STATUS_W-1:0] ST_BAD_SECOND = 3'd7;

	typedef logic [FIELD_W-1:0] field_t;
	typedef logic [NUM_FIELDS-1:0][FIELD_W-1:0] fields_t;

	// Parser state seen by the checker at end of string.
	typedef struct packed {
		fields_t             fields;
		logic [SEEN_W-1:0]   numbers_seen;
	} scan_state_t;

endpackage
`default_nettype wire

FILE: rtl/core/dtsp_scan.sv
// Character scanner: gap collapsing, length limit and field accumulation.
`default_nettype none
module dtsp_scan #(
	parameter int STRING_SIZE = dtsp_pkg::STRING_SIZE_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step,
	input  wire logic [7:0]         ch,
	output dtsp_pkg::scan_state_t   state
);
	import dtsp_pkg::*;

	localparam int KW = $clog2(STRING_SIZE);
	localparam logic [KW-1:0] KEPT_MAX = KW'(STRING_SIZE - 1);

	logic [KW-1:0]     kept_q, kept_d;
	logic              gap_q, gap_d;
	logic [SEEN_W-1:0] seen_q, seen_d;
	fields_t           fields_q, fields_d;

	logic              is_nul, is_digit, full, start;
	logic [3:0]        digit;
	field_t            sel_val;
	logic [ACC_W-1:0]  acc;
	field_t            acc_sat;

	assign is_nul   = (ch == CHAR_NUL);
	assign is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
	assign full     = (kept_q >= KEPT_MAX);
	assign start    = (kept_q == '0) || gap_q;
	assign digit    = 4'(ch - CHAR_ZERO);

	always_comb begin
		seen_d = seen_q;
		if (is_digit && start && (seen_q != SEEN_MAX)) begin
			seen_d = seen_q + 3'd1;
		end
	end

	// Pick the field being built; times ten as shift-add, then saturate.
	always_comb begin
		sel_val = '0;
		for (int k = 0; k < NUM_FIELDS; k++) begin
			if (seen_d == SEEN_W'(k + 1)) begin
				sel_val = fields_q[k];
			end
		end
		acc     = ({3'b000, sel_val} << 3) + ({3'b000, sel_val} << 1) + {13'd0, digit};
		acc_sat = (acc > {3'b000, SAT_VALUE}) ? SAT_VALUE : acc[FIELD_W-1:0];
	end

	always_comb begin
		kept_d   = kept_q;
		gap_d    = gap_q;
		fields_d = fields_q;
		if (is_nul) begin
			kept_d   = '0;
			gap_d    = 1'b0;
			fields_d = '0;
		end else if (!full) begin
			if (is_digit) begin
				for (int k = 0; k < NUM_FIELDS; k++) begin
					if (seen_d == SEEN_W'(k + 1)) begin
						fields_d[k] = acc_sat;
					end
				end
				kept_d = kept_q + KW'(1);
				gap_d  = 1'b0;
			end else if (!start) begin
				kept_d = kept_q + KW'(1);
				gap_d  = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_q   <= '0;
			gap_q    <= 1'b0;
			seen_q   <= '0;
			fields_q <= '0;
		end else if (step) begin
			kept_q   <= kept_d;
			gap_q    <= gap_d;
			seen_q   <= (is_nul) ? '0 : ((full) ? seen_q : seen_d);
			fields_q <= fields_d;
		end
	end

	assign state.fields       = fields_q;
	assign state.numbers_seen = seen_q;

endmodule
`default_nettype wire

FILE: rtl/core/dtsp_check.sv
// Format and range check of the six parsed numbers.
`default_nettype none
module dtsp_check (
	input  wire dtsp_pkg::scan_state_t     state,
	output logic [dtsp_pkg::STATUS_W-1:0]  status
);
	import dtsp_pkg::*;

	field_t yr, mo, dy, hr, mi, se;

	assign yr = state.fields[0];
	assign mo = state.fields[1];
	assign dy = state.fields[2];
	assign hr = state.fields[3];
	assign mi = state.fields[4];
	assign se = state.fields[5];

	always_comb begin
		if (state.numbers_seen < SEEN_W'(NUM_FIELDS)) begin
			status = ST_BAD_FORMAT;
		end else if (yr > YEAR_MAX) begin
			status = ST_BAD_YEAR;
		end else if ((mo == '0) || (mo > MONTH_MAX)) begin
			status = ST_BAD_MONTH;
		end else if ((dy == '0) || (dy > DAY_MAX)) begin
			status = ST_BAD_DAY;
		end else if (hr > HOUR_MAX) begin
			status = ST_BAD_HOUR;
		end else if (mi > MINSEC_MAX) begin
			status = ST_BAD_MINUTE;
		end else if (se > MINSEC_MAX) begin
			status = ST_BAD_SECOND;
		end else begin
			status = ST_OK;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/datetime_string_parser_unit.sv
// Top level of the date-time string parser: input register, scanner, checker, result register.
// A NUL word's result is written to the result register when the word leaves the input register.
// Throughput: one character word per cycle, except that a NUL word waits in the input register
// while an earlier result is not yet taken. The scanner state updates in a single step.
// Reset (arst_n low, asynchronous): clear the scanner state and both valid flags.
`default_nettype none
module datetime_string_parser_unit #(
	parameter int STRING_SIZE = dtsp_pkg::STRING_SIZE_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [7:0]                        character,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [dtsp_pkg::STATUS_W-1:0]          status,
	output logic [dtsp_pkg::FIELD_W-1:0]           year,
	output logic [dtsp_pkg::FIELD_W-1:0]           month,
	output logic [dtsp_pkg::FIELD_W-1:0]           day,
	output logic [dtsp_pkg::FIELD_W-1:0]           hour,
	output logic [dtsp_pkg::FIELD_W-1:0]           minute,
	output logic [dtsp_pkg::FIELD_W-1:0]           second
);
	import dtsp_pkg::*;

	// Input register: hold one character word.
	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        is_nul_s1;
	logic        advance;

	// Result register.
	logic                 out_valid_q;
	logic [STATUS_W-1:0]  status_q;
	fields_t              fields_q;

	scan_state_t          scan_state;
	logic [STATUS_W-1:0]  check_status;

	assign is_nul_s1 = (char_s1 == CHAR_NUL);

	// Advance the stored word unless it is a NUL and the result register is still full.
	assign advance  = valid_s1 && (!is_nul_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= character;
		end
	end

	dtsp_scan #(
		.STRING_SIZE (STRING_SIZE)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.ch     (char_s1),
		.state  (scan_state)
	);

	// Check the fields as they stand before the NUL clears them.
	dtsp_check u_check (
		.state  (scan_state),
		.status (check_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && is_nul_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_nul_s1) begin
			status_q <= check_status;
			fields_q <= scan_state.fields;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign year      = fields_q[0];
	assign month     = fields_q[1];
	assign day       = fields_q[2];
	assign hour      = fields_q[3];
	assign minute    = fields_q[4];
	assign second    = fields_q[5];

endmodule
`default_nettype wire
